FILE: sv/dfr_pkg.sv
package dfr_pkg;

    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] DIGIT_LO = 8'd48;
    localparam logic [BYTE_W-1:0] DIGIT_HI = 8'd57;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_LEN    = 2'd1,
        ERR_TOO_LARGE = 2'd2
    } t_err;

    typedef struct packed {
        logic clr;
        logic dig_en;
    } t_len_ctl;

    typedef struct packed {
        logic seen;
        logic ovf;
    } t_len_sts;

endpackage

FILE: sv/dfr_in_if.sv
interface dfr_in_if;
    import dfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

FILE: sv/dfr_out_if.sv
interface dfr_out_if;
    import dfr_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic              last_of_string;
    t_err              error_code;

    modport source (
        output valid, output data_byte, output byte_valid,
        output last_of_string, output error_code, input ready
    );
    modport sink (
        input valid, input data_byte, input byte_valid,
        input last_of_string, input error_code, output ready
    );
endinterface

FILE: sv/dfr_len_acc.sv
module dfr_len_acc #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dfr_pkg::t_len_ctl     i_ctl,
    input  logic [3:0]            i_digit,
    output logic [LEN_WIDTH-1:0]  o_len,
    output dfr_pkg::t_len_sts     o_sts
);
    import dfr_pkg::*;

    localparam int WIDE_W = LEN_WIDTH + 4;

    logic [LEN_WIDTH-1:0] r_len;
    logic                 r_seen;
    logic                 r_ovf;
    logic [WIDE_W-1:0]    n_wide;
    logic                 n_over;

    always_comb begin
        n_wide = ({4'b0, r_len} << 3) + ({4'b0, r_len} << 1) + WIDE_W'(i_digit);
        n_over = |n_wide[WIDE_W-1:LEN_WIDTH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_len  <= '0;
            r_seen <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_ctl.dig_en) begin
            r_seen <= 1'b1;
            if (r_ovf || n_over) begin
                r_ovf <= 1'b1;
                r_len <= '1;
            end else begin
                r_len <= n_wide[LEN_WIDTH-1:0];
            end
        end
    end

    assign o_len    = r_len;
    assign o_sts.seen = r_seen;
    assign o_sts.ovf  = r_ovf;

endmodule

FILE: sv/length_prefix_string_deframer.sv
// A result word is visible on o_out in the cycle after its input word is taken.
// Throughput: one input word per cycle; the phase and length update is a single
// registered step; a waiting result word stalls input only while o_out.ready is low.
// Reset (synchronous, i_rst_n low): phase returns to length reading, length,
// byte count and the result valid flag clear.
module length_prefix_string_deframer #(
    parameter int LEN_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfr_in_if.sink     i_in,
    dfr_out_if.source  o_out
);
    import dfr_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN     = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CLOSE   = 2'd2
    } t_phase;

    t_phase               r_phase;
    t_phase               n_phase;
    logic [LEN_WIDTH-1:0] r_left;
    logic [LEN_WIDTH-1:0] n_left;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_bvalid;
    logic              r_last;
    t_err              r_err;

    logic              n_emit;
    logic [BYTE_W-1:0] n_data;
    logic              n_bvalid;
    logic              n_last;
    t_err              n_err;

    logic                 acc;
    logic                 is_digit;
    logic [3:0]           digit_raw;
    t_len_ctl             len_ctl;
    t_len_sts             len_sts;
    logic [LEN_WIDTH-1:0] len_val;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;
    assign is_digit   = (i_in.in_byte >= DIGIT_LO) && (i_in.in_byte <= DIGIT_HI);
    assign digit_raw  = 4'(i_in.in_byte - DIGIT_LO);

    dfr_len_acc #(.LEN_WIDTH(LEN_WIDTH)) u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (len_ctl),
        .i_digit (digit_raw),
        .o_len   (len_val),
        .o_sts   (len_sts)
    );

    always_comb begin
        n_phase        = r_phase;
        n_left         = r_left;
        n_emit         = 1'b0;
        n_data         = '0;
        n_bvalid       = 1'b0;
        n_last         = 1'b0;
        n_err          = ERR_NONE;
        len_ctl.clr    = 1'b0;
        len_ctl.dig_en = 1'b0;
        if (acc) begin
            case (r_phase)
                PH_PAYLOAD: begin
                    n_emit   = 1'b1;
                    n_data   = i_in.in_byte;
                    n_bvalid = 1'b1;
                    n_last   = (r_left <= LEN_WIDTH'(1));
                    if (r_left != '0) begin
                        n_left = r_left - LEN_WIDTH'(1);
                    end
                    if (n_left == '0) begin
                        n_phase = PH_CLOSE;
                    end
                end
                PH_CLOSE: begin
                    n_phase = PH_LEN;
                end
                default: begin
                    n_phase = PH_LEN;
                    if (is_digit) begin
                        len_ctl.dig_en = 1'b1;
                    end else begin
                        len_ctl.clr = 1'b1;
                        if (!len_sts.seen) begin
                            n_emit = 1'b1;
                            n_err  = ERR_NO_LEN;
                        end else if (len_sts.ovf) begin
                            n_emit = 1'b1;
                            n_err  = ERR_TOO_LARGE;
                        end else if (len_val == '0) begin
                            n_emit  = 1'b1;
                            n_last  = 1'b1;
                            n_left  = '0;
                            n_phase = PH_CLOSE;
                        end else begin
                            n_left  = len_val;
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEN;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            if (acc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && n_emit) begin
            r_data   <= n_data;
            r_bvalid <= n_bvalid;
            r_last   <= n_last;
            r_err    <= n_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data_byte      = r_data;
    assign o_out.byte_valid     = r_bvalid;
    assign o_out.last_of_string = r_last;
    assign o_out.error_code     = r_err;

endmodule

FILE: sv/dfr_checker.sv
module dfr_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_ready,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [dfr_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                      i_byte_valid,
    input  logic                      i_last,
    input  dfr_pkg::t_err             i_err
);
    import dfr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_byte)
            && $stable(i_byte_valid) && $stable(i_last) && $stable(i_err))
        else $error("result word changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_err != ERR_NONE |-> !i_byte_valid && !i_last
            && i_data_byte == '0)
        else $error("error word carries payload");

    a_no_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_byte_valid |-> i_data_byte == '0
            && (i_last || i_err != ERR_NONE))
        else $error("marker word malformed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind length_prefix_string_deframer dfr_checker u_dfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_byte  (o_out.data_byte),
    .i_byte_valid (o_out.byte_valid),
    .i_last       (o_out.last_of_string),
    .i_err        (o_out.error_code)
);
